[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/core/wpbmf_pkg.sv]
package wpbmf_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int MAX_BUCKETS_DEF = 16;

  localparam logic [2:0] OP_SAMPLE = 3'd0;
  localparam logic [2:0] OP_WEIGHT = 3'd1;
  localparam logic [2:0] OP_DECAY  = 3'd2;
  localparam logic [2:0] OP_GAIN   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] REG_WINDOW_LEN   = 2'd0;
  localparam logic [1:0] REG_BUCKET_COUNT = 2'd1;
  localparam logic [1:0] REG_STEP_SCALE   = 2'd2;
  localparam logic [1:0] REG_CAPUTO_MODE  = 2'd3;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_PREP,
    S_WR,
    S_TAP_ADDR,
    S_TAP_MUL,
    S_TAP_ACC,
    S_WS,
    S_LOC_MUL,
    S_LOC,
    S_BK_ADDR,
    S_BK_M1,
    S_BK_M2,
    S_BK_SUM,
    S_BK_UPD,
    S_BK_G1,
    S_BK_G2,
    S_BK_GSUM,
    S_BK_GACC,
    S_DONE
  } state_t;

endpackage

[rtl/core/window_plus_bucket_memory_filter.sv]
// Window plus bucket memory filter.
// Input stream s_axis: one word per op (sample, table load or history clear).
// Output stream m_axis: one word per sample op, result in tdata, clip flag in tuser.
// Config channel cfg_*: register index and data, always ready; write only when idle.
// In a sample, one shared 32x33 multiplier walks every window tap (read, multiply,
// accumulate) and every bucket (four multiplies and their sums), and the window,
// weight, decay, gain and bucket memories each have one read port.
// A table load is written directly from the idle state; a clear op sweeps the
// window and bucket memories.
// Reset: registers return to their defaults, then a sweep zeroes every memory;
// s_axis_tready stays low meanwhile.
// A finished result waits in the output register; the block accepts the next word
// while it waits and only stalls at the end of that next sample if the receiver
// still holds off.
module window_plus_bucket_memory_filter
  import wpbmf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // op[2:0], value[34:3], index[40:35], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result[31:0]
  output logic [0:0]  m_axis_tuser,   // saturated[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NBW   = $clog2(MAX_BUCKETS + 1);
  localparam int CLR_N = (MAX_WINDOW > MAX_BUCKETS) ? MAX_WINDOW : MAX_BUCKETS;
  localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  localparam logic signed [63:0] B48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] B48_MIN = -64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] I32_MIN = -64'sh0000_0000_8000_0000;

  // memories
  logic signed [31:0] win_mem [MAX_WINDOW];
  logic signed [31:0] wgt_mem [MAX_WINDOW];
  logic signed [31:0] dec_mem [MAX_BUCKETS];
  logic signed [31:0] gain_mem [MAX_BUCKETS];
  logic signed [47:0] bk_mem [MAX_BUCKETS];

  state_t state, state_next;

  logic [6:0]         window_len;
  logic [4:0]         bucket_count;
  logic signed [31:0] step_scale;
  logic               caputo_mode;

  logic               clr_all;
  logic [CW-1:0]      clr_idx;
  logic signed [31:0] item_val;
  logic signed [31:0] x_val;
  logic signed [31:0] origin;
  logic               origin_cap;
  logic               sat;
  logic signed [31:0] dropped;
  logic [LW-1:0]      len;
  logic [NBW-1:0]     nb;
  logic [PW-1:0]      wp;
  logic [PW-1:0]      pos;
  logic [LW-1:0]      tap_j;
  logic [NBW-1:0]     bk;
  logic signed [63:0] acc;
  logic signed [31:0] ws;
  logic signed [47:0] local_part;
  logic signed [63:0] tail;
  logic signed [47:0] b_val;
  logic signed [47:0] m_val;
  logic signed [31:0] coef_d;
  logic signed [31:0] coef_g;
  logic signed [63:0] t_val;
  logic signed [63:0] sum1;
  logic signed [63:0] prod;

  logic               out_valid;
  logic [31:0]        out_result;
  logic               out_sat;

  logic signed [31:0] win_rdata, wgt_rdata, dec_rdata, gain_rdata;
  logic signed [47:0] bk_rdata;

  // input word fields
  logic [2:0]         in_op;
  logic signed [31:0] in_value;
  logic [5:0]         in_index;
  logic               in_fire;

  assign in_op    = s_axis_tdata[2:0];
  assign in_value = s_axis_tdata[34:3];
  assign in_index = s_axis_tdata[40:35];
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // effective length, count and write position
  logic [31:0]   len_c;
  logic [31:0]   nb_c;
  logic [PW-1:0] wp_eff;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] pos_dec;

  always_comb begin
    if (window_len == 7'd0) begin
      len_c = 32'd1;
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      len_c = 32'(MAX_WINDOW);
    end else begin
      len_c = 32'(window_len);
    end
    nb_c = (32'(bucket_count) > 32'(MAX_BUCKETS)) ? 32'(MAX_BUCKETS) : 32'(bucket_count);
    wp_eff  = (32'(wp) >= 32'(len)) ? '0 : wp;
    wp_inc  = (32'(wp) + 32'd1 >= 32'(len)) ? '0 : PW'(32'(wp) + 32'd1);
    pos_dec = (pos == '0) ? PW'(32'(len) - 32'd1) : PW'(32'(pos) - 32'd1);
  end

  // caputo difference
  logic signed [32:0] diff;
  logic signed [31:0] org_eff;
  logic               diff_hi, diff_lo;

  always_comb begin
    org_eff = origin_cap ? origin : item_val;
    diff    = 33'(item_val) - 33'(org_eff);
    diff_hi = diff > 33'sh0_7FFF_FFFF;
    diff_lo = diff < -33'sh0_8000_0000;
  end

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_p;

  always_comb begin
    mul_a = coef_g;
    mul_b = 33'($signed(m_val[47:16]));
    unique case (state)
      S_TAP_MUL: begin
        mul_a = wgt_rdata;
        mul_b = 33'(win_rdata);
      end
      S_LOC_MUL: begin
        mul_a = step_scale;
        mul_b = 33'(ws);
      end
      S_BK_M1: begin
        mul_a = dec_rdata;
        mul_b = 33'($signed(bk_rdata[47:16]));
      end
      S_BK_M2: begin
        mul_a = coef_d;
        mul_b = $signed({17'd0, b_val[15:0]});
      end
      S_BK_G2: begin
        mul_a = coef_g;
        mul_b = $signed({17'd0, m_val[15:0]});
      end
      default: begin
        mul_a = coef_g;
        mul_b = 33'($signed(m_val[47:16]));
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // bucket update and final sum
  logic signed [63:0] m_raw;
  logic signed [47:0] m_clip;
  logic               m_sat;
  logic signed [63:0] acc_sh;
  logic signed [31:0] ws_clip;
  logic               ws_sat;
  logic signed [63:0] total;
  logic [31:0]        res_clip;
  logic               res_sat;

  always_comb begin
    m_raw = (sum1 >>> 14) + 64'(dropped);
    m_sat = 1'b1;
    if (m_raw > B48_MAX) begin
      m_clip = B48_MAX[47:0];
    end else if (m_raw < B48_MIN) begin
      m_clip = B48_MIN[47:0];
    end else begin
      m_clip = m_raw[47:0];
      m_sat  = 1'b0;
    end

    acc_sh = acc >>> 16;
    ws_sat = 1'b1;
    if (acc_sh > I32_MAX) begin
      ws_clip = I32_MAX[31:0];
    end else if (acc_sh < I32_MIN) begin
      ws_clip = I32_MIN[31:0];
    end else begin
      ws_clip = acc_sh[31:0];
      ws_sat  = 1'b0;
    end

    total   = 64'(local_part) + tail;
    res_sat = 1'b1;
    if (total > I32_MAX) begin
      res_clip = I32_MAX[31:0];
    end else if (total < I32_MIN) begin
      res_clip = I32_MIN[31:0];
    end else begin
      res_clip = total[31:0];
      res_sat  = 1'b0;
    end
  end

  logic out_free;
  assign out_free = !out_valid || m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:      if (32'(clr_idx) == CLR_N - 1) state_next = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_SAMPLE) begin
            state_next = S_PREP;
          end else if (in_op == OP_CLEAR) begin
            state_next = S_CLR;
          end
        end
      end
      S_PREP:     state_next = S_WR;
      S_WR:       state_next = S_TAP_ADDR;
      S_TAP_ADDR: state_next = S_TAP_MUL;
      S_TAP_MUL:  state_next = S_TAP_ACC;
      S_TAP_ACC:  state_next = (32'(tap_j) + 32'd1 >= 32'(len)) ? S_WS : S_TAP_ADDR;
      S_WS:       state_next = S_LOC_MUL;
      S_LOC_MUL:  state_next = S_LOC;
      S_LOC:      state_next = (nb == '0) ? S_DONE : S_BK_ADDR;
      S_BK_ADDR:  state_next = S_BK_M1;
      S_BK_M1:    state_next = S_BK_M2;
      S_BK_M2:    state_next = S_BK_SUM;
      S_BK_SUM:   state_next = S_BK_UPD;
      S_BK_UPD:   state_next = S_BK_G1;
      S_BK_G1:    state_next = S_BK_G2;
      S_BK_G2:    state_next = S_BK_GSUM;
      S_BK_GSUM:  state_next = S_BK_GACC;
      S_BK_GACC:  state_next = (32'(bk) + 32'd1 >= 32'(nb)) ? S_DONE : S_BK_ADDR;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // memory ports
  logic               win_we;
  logic [PW-1:0]      win_waddr, win_raddr;
  logic signed [31:0] win_wdata;
  logic               bk_we;
  logic [BW-1:0]      bk_waddr, bk_raddr;
  logic signed [47:0] bk_wdata;
  logic               wgt_we, dec_we, gain_we;
  logic [PW-1:0]      wgt_addr;
  logic [BW-1:0]      tab_addr;
  logic signed [31:0] tab_wdata;
  logic               in_clr;

  always_comb begin
    in_clr    = (state == S_CLR);
    win_we    = 1'b0;
    win_waddr = wp;
    win_wdata = x_val;
    win_raddr = (state == S_PREP) ? wp_eff : pos_dec;
    bk_we     = 1'b0;
    bk_waddr  = bk[BW-1:0];
    bk_wdata  = m_clip;
    bk_raddr  = bk[BW-1:0];
    wgt_we    = 1'b0;
    dec_we    = 1'b0;
    gain_we   = 1'b0;
    wgt_addr  = PW'(in_index);
    tab_addr  = BW'(in_index);
    tab_wdata = in_value;
    if (in_clr) begin
      win_we    = 32'(clr_idx) < MAX_WINDOW;
      win_waddr = PW'(clr_idx);
      win_wdata = '0;
      bk_we     = 32'(clr_idx) < MAX_BUCKETS;
      bk_waddr  = BW'(clr_idx);
      bk_wdata  = '0;
      wgt_we    = clr_all && win_we;
      dec_we    = clr_all && bk_we;
      gain_we   = clr_all && bk_we;
      wgt_addr  = PW'(clr_idx);
      tab_addr  = BW'(clr_idx);
      tab_wdata = '0;
    end else if (state == S_WR) begin
      win_we = 1'b1;
    end else if (state == S_BK_UPD) begin
      bk_we = 1'b1;
    end else if (in_fire) begin
      wgt_we  = (in_op == OP_WEIGHT) && (32'(in_index) < MAX_WINDOW);
      dec_we  = (in_op == OP_DECAY) && (32'(in_index) < MAX_BUCKETS);
      gain_we = (in_op == OP_GAIN) && (32'(in_index) < MAX_BUCKETS);
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    win_rdata <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) wgt_mem[wgt_addr] <= tab_wdata;
    wgt_rdata <= wgt_mem[tap_j[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (dec_we) dec_mem[tab_addr] <= tab_wdata;
    dec_rdata <= dec_mem[bk[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (gain_we) gain_mem[tab_addr] <= tab_wdata;
    gain_rdata <= gain_mem[bk[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bk_we) bk_mem[bk_waddr] <= bk_wdata;
    bk_rdata <= bk_mem[bk_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len   <= 7'd1;
      bucket_count <= 5'd0;
      step_scale   <= 32'sd65536;
      caputo_mode  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LEN:   window_len   <= cfg_data[6:0];
        REG_BUCKET_COUNT: bucket_count <= cfg_data[4:0];
        REG_STEP_SCALE:   step_scale   <= cfg_data;
        REG_CAPUTO_MODE:  caputo_mode  <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_all    <= 1'b1;
      clr_idx    <= '0;
      wp         <= '0;
      origin     <= '0;
      origin_cap <= 1'b0;
    end else begin
      prod <= mul_p[63:0];
      unique case (state)
        S_CLR: begin
          clr_idx <= CW'(32'(clr_idx) + 32'd1);
        end
        S_IDLE: begin
          item_val <= in_value;
          len      <= LW'(len_c);
          nb       <= NBW'(nb_c);
          sat      <= 1'b0;
          if (in_fire && in_op == OP_CLEAR) begin
            clr_all    <= 1'b0;
            clr_idx    <= '0;
            wp         <= '0;
            origin     <= '0;
            origin_cap <= 1'b0;
          end
        end
        S_PREP: begin
          wp <= wp_eff;
          if (caputo_mode) begin
            if (!origin_cap) begin
              origin     <= item_val;
              origin_cap <= 1'b1;
            end
            if (diff_hi) begin
              x_val <= 32'sh7FFF_FFFF;
              sat   <= 1'b1;
            end else if (diff_lo) begin
              x_val <= -32'sh8000_0000;
              sat   <= 1'b1;
            end else begin
              x_val <= diff[31:0];
            end
          end else begin
            x_val <= item_val;
          end
        end
        S_WR: begin
          dropped <= win_rdata;
          wp      <= wp_inc;
          pos     <= wp_inc;
          tap_j   <= '0;
          acc     <= '0;
        end
        S_TAP_ADDR: pos <= pos_dec;
        S_TAP_MUL:  ;
        S_TAP_ACC: begin
          acc   <= acc + (prod >>> 14);
          tap_j <= LW'(32'(tap_j) + 32'd1);
        end
        S_WS: begin
          ws <= ws_clip;
          if (ws_sat) sat <= 1'b1;
        end
        S_LOC_MUL: ;
        S_LOC: begin
          local_part <= 48'(prod >>> 16);
          tail       <= '0;
          bk         <= '0;
        end
        S_BK_ADDR: ;
        S_BK_M1: begin
          b_val  <= bk_rdata;
          coef_d <= dec_rdata;
          coef_g <= gain_rdata;
        end
        S_BK_M2:  t_val <= prod;
        S_BK_SUM: sum1 <= t_val + (prod >>> 16);
        S_BK_UPD: begin
          m_val <= m_clip;
          if (m_sat) sat <= 1'b1;
        end
        S_BK_G1:   ;
        S_BK_G2:   t_val <= prod;
        S_BK_GSUM: sum1 <= t_val + (prod >>> 16);
        S_BK_GACC: begin
          tail <= tail + (sum1 >>> 14);
          bk   <= NBW'(32'(bk) + 32'd1);
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid  <= 1'b1;
      out_result <= res_clip;
      out_sat    <= sat || res_sat;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result;
  assign m_axis_tuser  = out_sat;

  `ASSERT_CLK(a_tap_in_range, clk, rst,
      (state == S_TAP_ADDR) |-> (32'(tap_j) < 32'(len)), "tap index past window length")
  `ASSERT_CLK(a_wp_in_range, clk, rst,
      (state == S_TAP_ADDR) |-> (32'(wp) < 32'(len)), "write position past window length")
  `ASSERT_CLK(a_bucket_in_range, clk, rst,
      (state == S_BK_ADDR) |-> (32'(bk) < 32'(nb)), "bucket index past bucket count")
  `ASSERT_NEVER(a_done_overwrite, clk, rst,
      (state == S_DONE) && out_free && out_valid && !m_axis_tready, "result overwritten")

endmodule
